>>> hw/rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg: shared types for the swept box collision pipeline
// Holds the per-axis record passed from the setup stage to the decision stage.
// ----------------------------------------------------------------------------
package sac_pkg;

  // Width of one signed coordinate and of the gap numerators
  localparam int unsigned CoordBits = 24;
  localparam int unsigned GapBits   = CoordBits + 2;

  // Per-axis setup result
  typedef struct packed {
    logic                        ok;      // axis allows a collision
    logic                        moving;  // velocity nonzero
    logic                        vpos;    // velocity positive
    logic signed [GapBits-1:0]   ne;      // entry numerator
    logic signed [GapBits-1:0]   nx;      // exit numerator
    logic [CoordBits-1:0]        den;     // |velocity|, or 1 when at rest
  } sac_axis_t;

endpackage

>>> hw/rtl/sac_axis.sv
// ----------------------------------------------------------------------------
// sac_axis: per-axis gap setup
// Forms entry / exit numerators and |v| for one axis, purely combinational.
// ----------------------------------------------------------------------------
module sac_axis (
  input  logic signed [sac_pkg::CoordBits-1:0] a_i,
  input  logic        [sac_pkg::CoordBits-2:0] aw_i,
  input  logic signed [sac_pkg::CoordBits-1:0] b_i,
  input  logic        [sac_pkg::CoordBits-2:0] bw_i,
  input  logic signed [sac_pkg::CoordBits-1:0] v_i,
  output sac_pkg::sac_axis_t                   axis_o
);
  import sac_pkg::*;

  logic signed [GapBits-1:0] a, b, aw, bw, v, a_end, b_end;

  assign a     = GapBits'(a_i);
  assign b     = GapBits'(b_i);
  assign aw    = GapBits'({1'b0, aw_i});
  assign bw    = GapBits'({1'b0, bw_i});
  assign v     = GapBits'(v_i);
  assign a_end = a + aw;
  assign b_end = b + bw;

  always_comb begin
    axis_o.moving = (v_i != '0);
    axis_o.vpos   = !v_i[CoordBits-1] && (v_i != '0);
    axis_o.ok     = 1'b1;
    axis_o.ne     = '0;
    axis_o.nx     = '0;
    axis_o.den    = CoordBits'(1);
    if (v_i == '0) begin
      if ((a_end < b) || (b_end < a)) axis_o.ok = 1'b0;
    end else if (!v_i[CoordBits-1]) begin
      axis_o.ne  = b - a_end;
      axis_o.nx  = b_end - a;
      axis_o.den = v_i;
    end else begin
      axis_o.ne  = a - b_end;
      axis_o.nx  = a_end - b;
      axis_o.den = CoordBits'(-v);
    end
  end

endmodule

>>> hw/rtl/sac_div.sv
// ----------------------------------------------------------------------------
// sac_div: pipelined restoring fraction divider
// floor(n * 2^TimeBits / d) for 0 <= n < d, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sac_div #(
  parameter int unsigned TimeBits = 16,
  parameter int unsigned DenBits  = 24,
  parameter int unsigned TagBits  = 8
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [DenBits-1:0]  n_i,
  input  logic [DenBits-1:0]  d_i,
  input  logic [TagBits-1:0]  tag_i,
  output logic [TimeBits-1:0] q_o,
  output logic [TagBits-1:0]  tag_o
);
  // Partial remainder stays below d, so it fits in DenBits
  logic [DenBits-1:0]  r_q [1:TimeBits-1];
  logic [DenBits-1:0]  d_q [1:TimeBits-1];
  logic [TimeBits-1:0] q_q [1:TimeBits];
  logic [TagBits-1:0]  t_q [1:TimeBits];

  // One shift-subtract step per register stage
  for (genvar i = 0; i < TimeBits; i++) begin : g_step
    logic [DenBits-1:0]  r_in;
    logic [DenBits-1:0]  d_in;
    logic [TimeBits-1:0] q_in;
    logic [TagBits-1:0]  t_in;
    logic [DenBits:0]    sh;
    logic                ge;

    if (i == 0) begin : g_first
      assign r_in = n_i;
      assign d_in = d_i;
      assign q_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign r_in = r_q[i];
      assign d_in = d_q[i];
      assign q_in = q_q[i];
      assign t_in = t_q[i];
    end

    assign sh = {r_in, 1'b0};
    assign ge = (sh >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i+1] <= {q_in[TimeBits-2:0], ge};
        t_q[i+1] <= t_in;
      end
    end

    // Remainder and divisor are not needed past the last step
    if (i < TimeBits - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[i+1] <= DenBits'(ge ? sh - {1'b0, d_in} : sh);
          d_q[i+1] <= d_in;
        end
      end
    end
  end

  assign q_o   = q_q[TimeBits];
  assign tag_o = t_q[TimeBits];

endmodule

>>> hw/rtl/swept_aabb_collision.sv
// ----------------------------------------------------------------------------
// swept_aabb_collision: 2D swept box test, fully pipelined
// Accepts one box pair per cycle while the output is not stalled; the
// entry-time divider computes one quotient bit per stage, and a setup
// stage, a cross-product stage and a decision stage come before it.
// Backpressure freezes the whole pipe.
// ----------------------------------------------------------------------------
module swept_aabb_collision #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [23:0]     first_x_i,
  input  logic signed [23:0]     first_y_i,
  input  logic        [22:0]     first_w_i,
  input  logic        [22:0]     first_h_i,
  input  logic signed [23:0]     second_x_i,
  input  logic signed [23:0]     second_y_i,
  input  logic        [22:0]     second_w_i,
  input  logic        [22:0]     second_h_i,
  input  logic signed [23:0]     vel_x_i,
  input  logic signed [23:0]     vel_y_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic                   overlap_o,
  output logic                   hit_o,
  output logic [TIME_BITS:0]     entry_time_o,
  output logic signed [1:0]      normal_x_o,
  output logic signed [1:0]      normal_y_o
);
  import sac_pkg::*;

  localparam int unsigned Depth   = TIME_BITS + 3;
  localparam int unsigned ProdBits = GapBits + CoordBits;
  localparam int unsigned TagBits = 6;

  logic en;
  logic [Depth-1:0] vld_q;

  // Pipe advances unless the output holds an untaken item
  assign en      = !valid_o || ready_i;
  assign ready_o = en;
  assign valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  // Stage 1: per-axis setup and static overlap
  sac_axis_t ax_d, ay_d, ax_q, ay_q;
  logic ovl_d, ovl_q;
  logic signed [GapBits-1:0] fx, fy, sx, sy, fw, fh, sw, sh;

  sac_axis u_ax (.a_i(first_x_i), .aw_i(first_w_i), .b_i(second_x_i),
                 .bw_i(second_w_i), .v_i(vel_x_i), .axis_o(ax_d));
  sac_axis u_ay (.a_i(first_y_i), .aw_i(first_h_i), .b_i(second_y_i),
                 .bw_i(second_h_i), .v_i(vel_y_i), .axis_o(ay_d));

  assign fx = GapBits'(first_x_i);
  assign fy = GapBits'(first_y_i);
  assign sx = GapBits'(second_x_i);
  assign sy = GapBits'(second_y_i);
  assign fw = GapBits'({1'b0, first_w_i});
  assign fh = GapBits'({1'b0, first_h_i});
  assign sw = GapBits'({1'b0, second_w_i});
  assign sh = GapBits'({1'b0, second_h_i});
  assign ovl_d = (fx < sx + sw) && (fx + fw > sx) && (fy < sy + sh) && (fy + fh > sy);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      ovl_q <= ovl_d;
    end
  end

  // Stage 2: cross products for the exact time compares
  logic signed [ProdBits-1:0] xe_yd_q, ye_xd_q, yx_xd_q, xx_yd_q;
  sac_axis_t ax2_q, ay2_q;
  logic ovl2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xe_yd_q <= ax_q.ne * $signed({1'b0, ay_q.den});
      ye_xd_q <= ay_q.ne * $signed({1'b0, ax_q.den});
      yx_xd_q <= ay_q.nx * $signed({1'b0, ax_q.den});
      xx_yd_q <= ax_q.nx * $signed({1'b0, ay_q.den});
      ax2_q   <= ax_q;
      ay2_q   <= ay_q;
      ovl2_q  <= ovl_q;
    end
  end

  // Stage 3: later-entry axis, hit decision
  logic xlater, hit_d, full_d;
  logic signed [GapBits-1:0] en_n;
  logic [CoordBits-1:0] en_d;
  logic [CoordBits-1:0] n3_q, d3_q;
  logic [TagBits-1:0] tag3_q;

  always_comb begin
    xlater = 1'b0;
    hit_d  = 1'b0;
    if (ax2_q.ok && ay2_q.ok && (ax2_q.moving || ay2_q.moving)) begin
      if (ax2_q.moving && ay2_q.moving) xlater = xe_yd_q > ye_xd_q;
      else xlater = ax2_q.moving;
    end
    en_n = xlater ? ax2_q.ne : ay2_q.ne;
    en_d = xlater ? ax2_q.den : ay2_q.den;
    if (ax2_q.ok && ay2_q.ok && (ax2_q.moving || ay2_q.moving)) begin
      hit_d = !en_n[GapBits-1] && (en_n <= $signed({2'b00, en_d}));
      if (hit_d && ax2_q.moving && ay2_q.moving &&
          ((xe_yd_q > yx_xd_q) || (ye_xd_q > xx_yd_q))) hit_d = 1'b0;
    end
    full_d = hit_d && (en_n == $signed({2'b00, en_d}));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n3_q   <= (hit_d && !full_d) ? en_n[CoordBits-1:0] : '0;
      d3_q   <= en_d;
      // tag: overlap, hit, full, xlater, vx>0, vy>0
      tag3_q <= {ovl2_q, hit_d, full_d, xlater, ax2_q.vpos, ay2_q.vpos};
    end
  end

  // Stages 4..: entry time division
  logic [TIME_BITS-1:0] q;
  logic [TagBits-1:0] tg;

  sac_div #(.TimeBits(TIME_BITS), .DenBits(CoordBits), .TagBits(TagBits)) u_div (
    .clk_i(clk_i), .en_i(en), .n_i(n3_q), .d_i(d3_q), .tag_i(tag3_q),
    .q_o(q), .tag_o(tg)
  );

  // Output formatting
  always_comb begin
    overlap_o    = tg[5];
    hit_o        = tg[4];
    entry_time_o = !tg[4] ? '0 : tg[3] ? {1'b1, {TIME_BITS{1'b0}}} : {1'b0, q};
    normal_x_o   = (tg[4] && tg[2])  ? (tg[1] ? -2'sd1 : 2'sd1) : 2'sd0;
    normal_y_o   = (tg[4] && !tg[2]) ? (tg[0] ? -2'sd1 : 2'sd1) : 2'sd0;
  end

endmodule
